[rtl/core/wvt_pkg.sv]
// Shared types and fixed widths of the wireframe vertex transform core.
// No dependencies; imported by wireframe_vertex_transform_core.
`timescale 1ns / 1ps
`default_nettype none

package wvt_pkg;

   // Field widths of the request and response beats
   localparam int VERT_W  = 12;
   localparam int ANGLE_W = 16;
   localparam int SCALE_W = 9;
   localparam int COORD_W = 14;

   // Shared multiplier operands and accumulator
   localparam int MUL_A_W = 28;
   localparam int MUL_B_W = 17;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 36;

   // Sine table entries are unsigned Q1.14, signed trig values take two more bits
   localparam int SINE_W = 15;
   localparam int TRIG_W = 17;
   localparam int Q14_ONE = 16384;

   // Rounding of the Q.26 product down to Q10.4
   localparam int FRAC_DROP = 22;

   // Taylor series constants for the table build
   localparam longint unsigned PI_Q30 = 64'd3373259426;
   localparam int TAYLOR_TERMS = 7;
   localparam longint unsigned TERM_DIV [TAYLOR_TERMS] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
   };

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_PHASE,
      S_SIN_RD,
      S_COS_RD,
      S_MUL_XC,
      S_MUL_XS,
      S_MUL_XK,
      S_MUL_YS,
      S_MUL_YC,
      S_MUL_YK,
      S_ROUND_Y,
      S_ANCHOR,
      S_EDGE,
      S_CLOSE
   } state_type;

   // Round half up to Q10.4, add the position, saturate to the coordinate range
   function automatic logic signed [COORD_W-1:0] round_sat(
      input logic signed [ACC_W-1:0]   acc,
      input logic signed [COORD_W-1:0] pos
   );
      logic signed [ACC_W:0]   biased;
      logic signed [COORD_W:0] whole;
      logic signed [COORD_W+1:0] sum;
      biased = $signed({acc[ACC_W-1], acc}) + $signed((ACC_W+1)'(1) <<< (FRAC_DROP - 1));
      whole  = biased[ACC_W:FRAC_DROP];
      sum    = $signed({whole[COORD_W], whole}) + $signed({{2{pos[COORD_W-1]}}, pos});
      if (sum < $signed(-(COORD_W+2)'(2 ** (COORD_W - 1)))) begin
         round_sat = {1'b1, {(COORD_W-1){1'b0}}};
      end else if (sum > $signed((COORD_W+2)'(2 ** (COORD_W - 1) - 1))) begin
         round_sat = {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
         round_sat = sum[COORD_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

[rtl/core/wireframe_vertex_transform_core.sv]
// Wireframe vertex transform core: rotate, scale and translate one vertex per
// request beat, emit the closed-polygon edges. Depends on wvt_pkg.
//
// Usage:
//   The request channel carries one model vertex with the object's pose
//   (angle, scale, position) and a flag on the last vertex of the model.
//   The response channel carries polygon edges: one per vertex after the
//   first, plus the closing edge (closing = 1) after the last vertex.
//   A single vertex marked last gives one zero-length closing edge.
//   A beat moves when valid is high and stall is low.
//   Each vertex passes through the phase, table read, multiply, round and
//   anchor states before its first response beat, which waits while
//   rsp_stall is high. The pace is set by the one shared 28x17 multiplier,
//   used six times per vertex plus once for the table phase, and by the one
//   read port of the sine table, read twice. req_stall is high from accept
//   until the last response beat of that vertex has moved, or, for a vertex
//   with no response beat, until its sequence ends.
//   A stalled response holds its payload until taken.
//   Reset (synchronous, active high) returns to idle and forgets any
//   polygon in progress; the sine table is a constant and needs no fill.
`timescale 1ns / 1ps
`default_nettype none

module wireframe_vertex_transform_core #(
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [wvt_pkg::VERT_W-1:0]   req_vertex_x,
   input  logic signed [wvt_pkg::VERT_W-1:0]   req_vertex_y,
   input  logic        [wvt_pkg::ANGLE_W-1:0]  req_angle,
   input  logic        [wvt_pkg::SCALE_W-1:0]  req_scale,
   input  logic signed [wvt_pkg::COORD_W-1:0]  req_pos_x,
   input  logic signed [wvt_pkg::COORD_W-1:0]  req_pos_y,
   input  logic                                req_last_vertex,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [wvt_pkg::COORD_W-1:0]  rsp_start_x,
   output logic signed [wvt_pkg::COORD_W-1:0]  rsp_start_y,
   output logic signed [wvt_pkg::COORD_W-1:0]  rsp_end_x,
   output logic signed [wvt_pkg::COORD_W-1:0]  rsp_end_y,
   output logic                                rsp_closing
);
   import wvt_pkg::*;

   localparam int ROM_AW = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int PH_W   = $clog2(4 * SINE_TABLE_DEPTH);

   typedef logic [SINE_W-1:0] rom_type [SINE_TABLE_DEPTH + 1];

   // Quarter-wave sine entry k in Q1.14 from a Q30 Taylor series
   function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned k);
      longint unsigned x;
      longint unsigned term;
      longint          sum;
      int              n;
      x    = (PI_Q30 * longint'(k)) / (2 * SINE_TABLE_DEPTH);
      term = x;
      sum  = longint'(x);
      for (n = 1; n <= TAYLOR_TERMS; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / TERM_DIV[n-1];
         if ((n % 2) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      sum = (sum + 32768) >>> 16;
      if (sum > Q14_ONE) begin
         sum = Q14_ONE;
      end
      quarter_sine = SINE_W'(sum);
   endfunction

   function automatic rom_type build_rom();
      rom_type t;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         t[k] = quarter_sine(k);
      end
      build_rom = t;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // Sequencer and datapath registers
   state_type state_ff, state_in;

   logic signed [VERT_W-1:0]  vx_ff, vy_ff;
   logic        [ANGLE_W-1:0] angle_ff;
   logic        [SCALE_W-1:0] scale_ff;
   logic signed [COORD_W-1:0] pos_x_ff, pos_y_ff;
   logic                      last_ff;

   logic        [PH_W-1:0]    phase_ff;
   logic        [1:0]         quad_ff;
   logic        [ROM_AW-1:0]  idx_ff;
   logic        [ROM_AW-1:0]  rom_addr;
   logic        [SINE_W-1:0]  rom_q_ff;
   logic signed [TRIG_W-1:0]  sin_ff, cos_ff, cos_now;

   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;
   logic signed [ACC_W-1:0]   prod;

   logic signed [COORD_W-1:0] cur_x_ff, cur_y_ff;
   logic signed [COORD_W-1:0] first_x_ff, first_y_ff;
   logic signed [COORD_W-1:0] prev_x_ff, prev_y_ff;
   logic                      have_prev_ff;

   logic                      req_take;
   logic                      rsp_take;
   logic                      finish;
   logic        [1:0]         quad_now;
   logic        [ROM_AW-1:0]  idx_now;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;
   assign finish   = (state_ff != S_IDLE) && (state_in == S_IDLE);

   // Split the phase into quadrant and table index
   always_comb begin
      if (phase_ff >= PH_W'(3 * SINE_TABLE_DEPTH)) begin
         quad_now = 2'd3;
         idx_now  = ROM_AW'(phase_ff - PH_W'(3 * SINE_TABLE_DEPTH));
      end else if (phase_ff >= PH_W'(2 * SINE_TABLE_DEPTH)) begin
         quad_now = 2'd2;
         idx_now  = ROM_AW'(phase_ff - PH_W'(2 * SINE_TABLE_DEPTH));
      end else if (phase_ff >= PH_W'(SINE_TABLE_DEPTH)) begin
         quad_now = 2'd1;
         idx_now  = ROM_AW'(phase_ff - PH_W'(SINE_TABLE_DEPTH));
      end else begin
         quad_now = 2'd0;
         idx_now  = ROM_AW'(phase_ff);
      end
   end

   // Table address: sine in the read state, cosine one quadrant on
   always_comb begin
      if (state_ff == S_SIN_RD) begin
         rom_addr = quad_now[0] ? (ROM_AW'(SINE_TABLE_DEPTH) - idx_now) : idx_now;
      end else begin
         rom_addr = quad_ff[0] ? idx_ff : (ROM_AW'(SINE_TABLE_DEPTH) - idx_ff);
      end
   end

   // Registered table read
   always_ff @(posedge clock) begin
      rom_q_ff <= SINE_ROM[rom_addr];
   end

   // Cosine is negative in quadrants one and two
   always_comb begin
      if (quad_ff == 2'd1 || quad_ff == 2'd2) begin
         cos_now = -$signed({2'b00, rom_q_ff});
      end else begin
         cos_now = $signed({2'b00, rom_q_ff});
      end
   end

   // Select operands of the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_PHASE: begin
            mul_a = $signed(MUL_A_W'(angle_ff));
            mul_b = $signed(MUL_B_W'(SINE_TABLE_DEPTH));
         end
         S_MUL_XC: begin
            mul_a = MUL_A_W'(vx_ff);
            mul_b = MUL_B_W'(cos_now);
         end
         S_MUL_XS: begin
            mul_a = MUL_A_W'(vy_ff);
            mul_b = MUL_B_W'(sin_ff);
         end
         S_MUL_YS: begin
            mul_a = MUL_A_W'(vx_ff);
            mul_b = MUL_B_W'(sin_ff);
         end
         S_MUL_YC: begin
            mul_a = MUL_A_W'(vy_ff);
            mul_b = MUL_B_W'(cos_ff);
         end
         S_MUL_XK, S_MUL_YK: begin
            mul_a = acc_ff[MUL_A_W-1:0];
            mul_b = $signed(MUL_B_W'(scale_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;
   assign prod  = mul_p[ACC_W-1:0];

   // Accumulate: load, subtract or add the product
   always_comb begin
      case (state_ff)
         S_MUL_XC, S_MUL_XK, S_MUL_YS, S_MUL_YK: acc_in = prod;
         S_MUL_XS: acc_in = acc_ff - prod;
         S_MUL_YC: acc_in = acc_ff + prod;
         default:  acc_in = acc_ff;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:    if (req_take) state_in = S_PHASE;
         S_PHASE:   state_in = S_SIN_RD;
         S_SIN_RD:  state_in = S_COS_RD;
         S_COS_RD:  state_in = S_MUL_XC;
         S_MUL_XC:  state_in = S_MUL_XS;
         S_MUL_XS:  state_in = S_MUL_XK;
         S_MUL_XK:  state_in = S_MUL_YS;
         S_MUL_YS:  state_in = S_MUL_YC;
         S_MUL_YC:  state_in = S_MUL_YK;
         S_MUL_YK:  state_in = S_ROUND_Y;
         S_ROUND_Y: state_in = S_ANCHOR;
         S_ANCHOR: begin
            if (have_prev_ff) begin
               state_in = S_EDGE;
            end else if (last_ff) begin
               state_in = S_CLOSE;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EDGE: begin
            if (rsp_take) state_in = last_ff ? S_CLOSE : S_IDLE;
         end
         S_CLOSE: begin
            if (rsp_take) state_in = S_IDLE;
         end
         default:   state_in = S_IDLE;
      endcase
   end

   // Outputs: handshake and response payload
   always_comb begin
      req_stall   = (state_ff != S_IDLE);
      rsp_valid   = 1'b0;
      rsp_start_x = cur_x_ff;
      rsp_start_y = cur_y_ff;
      rsp_end_x   = first_x_ff;
      rsp_end_y   = first_y_ff;
      rsp_closing = 1'b1;
      case (state_ff)
         S_EDGE: begin
            rsp_valid   = 1'b1;
            rsp_start_x = prev_x_ff;
            rsp_start_y = prev_y_ff;
            rsp_end_x   = cur_x_ff;
            rsp_end_y   = cur_y_ff;
            rsp_closing = 1'b0;
         end
         S_CLOSE: begin
            rsp_valid   = 1'b1;
         end
         default: begin
            rsp_valid   = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         have_prev_ff <= 1'b0;
         first_x_ff   <= '0;
         first_y_ff   <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
      end else begin
         state_ff <= state_in;
         // anchor the polygon on its first vertex
         if (state_ff == S_ANCHOR && !have_prev_ff) begin
            first_x_ff <= cur_x_ff;
            first_y_ff <= cur_y_ff;
         end
         // advance the previous vertex once all beats have moved
         if (finish) begin
            prev_x_ff    <= cur_x_ff;
            prev_y_ff    <= cur_y_ff;
            have_prev_ff <= !last_ff;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         vx_ff    <= req_vertex_x;
         vy_ff    <= req_vertex_y;
         angle_ff <= req_angle;
         scale_ff <= req_scale;
         pos_x_ff <= req_pos_x;
         pos_y_ff <= req_pos_y;
         last_ff  <= req_last_vertex;
      end
      if (state_ff == S_PHASE) begin
         phase_ff <= mul_p[PH_W+13:14];
      end
      if (state_ff == S_SIN_RD) begin
         quad_ff <= quad_now;
         idx_ff  <= idx_now;
      end
      // sine is negative in the lower half turn
      if (state_ff == S_COS_RD) begin
         sin_ff <= quad_ff[1] ? -$signed({2'b00, rom_q_ff}) : $signed({2'b00, rom_q_ff});
      end
      if (state_ff == S_MUL_XC) begin
         cos_ff <= cos_now;
      end
      acc_ff <= acc_in;
      // x is final in the accumulator while y starts
      if (state_ff == S_MUL_YS) begin
         cur_x_ff <= round_sat(acc_ff, pos_x_ff);
      end
      if (state_ff == S_ROUND_Y) begin
         cur_y_ff <= round_sat(acc_ff, pos_y_ff);
      end
   end

endmodule

`default_nettype wire

[test/tb_wireframe_vertex_transform_core.sv]
// Self-checking bench for wireframe_vertex_transform_core: directed table plus random polygons,
// every edge beat checked against its typed edges or an in-bench fixed-point transform and
// polygon tracker. Depends on wvt_pkg and wireframe_vertex_transform_core.
`timescale 1ns / 1ps
`default_nettype none

module tb_wireframe_vertex_transform_core;
   import wvt_pkg::*;

   localparam int DEPTH      = 256;
   localparam int COORD_LO   = -(2 ** (COORD_W - 1));
   localparam int COORD_HI   = 2 ** (COORD_W - 1) - 1;
   localparam int TAIL_CYCLES = 20;

   typedef struct {
      logic signed [VERT_W-1:0]  vx;
      logic signed [VERT_W-1:0]  vy;
      logic        [ANGLE_W-1:0] angle;
      logic        [SCALE_W-1:0] scale;
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      logic                      last;
   } vertex_type;

   typedef struct {
      logic signed [COORD_W-1:0] sx;
      logic signed [COORD_W-1:0] sy;
      logic signed [COORD_W-1:0] ex;
      logic signed [COORD_W-1:0] ey;
      logic                      closing;
   } edge_type;

   // One stimulus row: typed rows carry their own edges, others use the transform
   typedef struct {
      vertex_type v;
      bit         typed;
      int         n_edges;
      edge_type   e0;
      edge_type   e1;
   } vertex_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [VERT_W-1:0]  req_vertex_x = '0;
   logic signed [VERT_W-1:0]  req_vertex_y = '0;
   logic        [ANGLE_W-1:0] req_angle = '0;
   logic        [SCALE_W-1:0] req_scale = '0;
   logic signed [COORD_W-1:0] req_pos_x = '0;
   logic signed [COORD_W-1:0] req_pos_y = '0;
   logic                      req_last_vertex = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [COORD_W-1:0] rsp_start_x;
   logic signed [COORD_W-1:0] rsp_start_y;
   logic signed [COORD_W-1:0] rsp_end_x;
   logic signed [COORD_W-1:0] rsp_end_y;
   logic                      rsp_closing;

   // Quarter-wave sine in Q1.14 and the polygon tracker state
   int                        quarter_wave [0:DEPTH];
   logic signed [COORD_W-1:0] poly_first_x = '0;
   logic signed [COORD_W-1:0] poly_first_y = '0;
   logic signed [COORD_W-1:0] poly_prev_x = '0;
   logic signed [COORD_W-1:0] poly_prev_y = '0;
   bit                        poly_open = 1'b0;

   edge_type       pending_edges [$];
   vertex_row_type vertex_rows [$];

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int vertices_sent = 0;
   int edges_seen = 0;
   int closing_seen = 0;
   int mismatches = 0;

   wireframe_vertex_transform_core #(
      .SINE_TABLE_DEPTH(DEPTH)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_vertex_x   (req_vertex_x),
      .req_vertex_y   (req_vertex_y),
      .req_angle      (req_angle),
      .req_scale      (req_scale),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_last_vertex(req_last_vertex),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_start_x    (rsp_start_x),
      .rsp_start_y    (rsp_start_y),
      .rsp_end_x      (rsp_end_x),
      .rsp_end_y      (rsp_end_y),
      .rsp_closing    (rsp_closing)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
   endtask

   // Append an edge to the tail of the expected queue
   function automatic void queue_edge(input edge_type e);
      pending_edges.insert(pending_edges.size(), e);
   endfunction

   // Append a row to the directed table
   function automatic void add_row(input vertex_row_type row);
      vertex_rows.insert(vertex_rows.size(), row);
   endfunction

   function automatic vertex_type mk_vertex(input int vx, input int vy, input int ang,
                                            input int sc, input int px, input int py,
                                            input bit last);
      vertex_type v;
      v.vx    = VERT_W'(vx);
      v.vy    = VERT_W'(vy);
      v.angle = ANGLE_W'(ang);
      v.scale = SCALE_W'(sc);
      v.px    = COORD_W'(px);
      v.py    = COORD_W'(py);
      v.last  = last;
      return v;
   endfunction

   function automatic edge_type mk_edge(input int sx, input int sy, input int ex, input int ey,
                                        input bit closing);
      edge_type e;
      e.sx      = COORD_W'(sx);
      e.sy      = COORD_W'(sy);
      e.ex      = COORD_W'(ex);
      e.ey      = COORD_W'(ey);
      e.closing = closing;
      return e;
   endfunction

   // Field value with the extremes of its range weighted up
   function automatic logic [15:0] pick_bits(input int w, input bit sgn);
      logic [15:0] m;
      int          r;
      m = 16'((32'h1 << w) - 1);
      r = $urandom_range(15);
      if (r == 0) begin
         return sgn ? 16'(32'h1 << (w - 1)) : 16'h0;
      end else if (r == 1) begin
         return sgn ? (m >> 1) : m;
      end
      return 16'($urandom) & m;
   endfunction

   function automatic vertex_type random_vertex();
      vertex_type v;
      v.vx    = VERT_W'(pick_bits(VERT_W, 1'b1));
      v.vy    = VERT_W'(pick_bits(VERT_W, 1'b1));
      v.angle = ANGLE_W'(pick_bits(ANGLE_W, 1'b0));
      v.scale = SCALE_W'(pick_bits(SCALE_W, 1'b0));
      v.px    = COORD_W'(pick_bits(COORD_W, 1'b1));
      v.py    = COORD_W'(pick_bits(COORD_W, 1'b1));
      v.last  = 1'($urandom_range(1));
      return v;
   endfunction

   // Signed sine of a phase in [0, 4*DEPTH) from the quarter-wave table
   function automatic int wave_sine(input int unsigned p);
      int unsigned q;
      int unsigned i;
      p = p % (4 * DEPTH);
      q = p / DEPTH;
      i = p % DEPTH;
      case (q)
         0: return quarter_wave[i];
         1: return quarter_wave[DEPTH - i];
         2: return -quarter_wave[i];
         default: return -quarter_wave[DEPTH - i];
      endcase
   endfunction

   // Round Q.26 half toward plus infinity to Q10.4, offset and saturate
   function automatic logic signed [COORD_W-1:0] place_coord(input longint prod,
                                                             input longint pos);
      longint r;
      r = ((prod + (64'sd1 <<< (FRAC_DROP - 1))) >>> FRAC_DROP) + pos;
      if (r < COORD_LO) r = COORD_LO;
      if (r > COORD_HI) r = COORD_HI;
      return COORD_W'(r);
   endfunction

   // Transform one vertex, advance the polygon, queue the edges it closes
   task automatic trace_edges(input vertex_type v, input bit queue_it);
      int unsigned               p;
      longint                    s, c, vx, vy, sc, rx, ry;
      logic signed [COORD_W-1:0] cx, cy;
      p  = (int'(v.angle) * DEPTH) >> 14;
      s  = wave_sine(p);
      c  = wave_sine(p + DEPTH);
      vx = longint'(v.vx);
      vy = longint'(v.vy);
      sc = longint'({1'b0, v.scale});
      rx = vx * c - vy * s;
      ry = vx * s + vy * c;
      cx = place_coord(rx * sc, longint'(v.px));
      cy = place_coord(ry * sc, longint'(v.py));
      if (poly_open) begin
         if (queue_it) queue_edge(mk_edge(poly_prev_x, poly_prev_y, cx, cy, 1'b0));
      end else begin
         poly_first_x = cx;
         poly_first_y = cy;
      end
      if (v.last) begin
         if (queue_it) begin
            queue_edge(mk_edge(cx, cy, poly_first_x, poly_first_y, 1'b1));
         end
         poly_open = 1'b0;
      end else begin
         poly_open = 1'b1;
      end
      poly_prev_x = cx;
      poly_prev_y = cy;
   endtask

   // Drive one request beat at the falling edge and hold it until accepted
   task automatic send_vertex(input vertex_type v);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_vertex_x    <= v.vx;
      req_vertex_y    <= v.vy;
      req_angle       <= v.angle;
      req_scale       <= v.scale;
      req_pos_x       <= v.px;
      req_pos_y       <= v.py;
      req_last_vertex <= v.last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      vertices_sent++;
   endtask

   // Hold the sender off until every queued edge has come back
   task automatic drain_edges();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_edges.size() != 0) @(negedge clock);
   endtask

   // Random polygons: mostly well-formed with a shared pose, some with broken last flags
   task automatic run_polygons(input int items);
      int         target, len, i;
      bit         broken, shared;
      vertex_type pose, v;
      target = vertices_sent + items;
      while (vertices_sent < target) begin
         len    = ($urandom_range(9) == 0) ? 1 : $urandom_range(6, 2);
         broken = ($urandom_range(99) < 15);
         shared = ($urandom_range(99) < 80);
         pose   = random_vertex();
         for (i = 0; i < len; i++) begin
            v = random_vertex();
            if (shared) begin
               v.angle = pose.angle;
               v.scale = pose.scale;
               v.px    = pose.px;
               v.py    = pose.py;
            end
            if (!broken) v.last = (i == len - 1);
            send_vertex(v);
            trace_edges(v, 1'b1);
         end
      end
   endtask

   // Receiver backpressure, changed only at the falling edge
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // Check each accepted edge beat against the oldest queued edge
   always @(posedge clock) begin
      edge_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         edges_seen++;
         if (rsp_closing) closing_seen++;
         if (pending_edges.size() == 0) begin
            report_mismatch($sformatf("unexpected edge (%0d,%0d)->(%0d,%0d) closing=%0b",
               rsp_start_x, rsp_start_y, rsp_end_x, rsp_end_y, rsp_closing));
         end else begin
            want = pending_edges.pop_front();
            if (rsp_start_x !== want.sx || rsp_start_y !== want.sy ||
                rsp_end_x !== want.ex || rsp_end_y !== want.ey ||
                rsp_closing !== want.closing) begin
               report_mismatch($sformatf(
                  "edge %0d got (%0d,%0d)->(%0d,%0d) c=%0b want (%0d,%0d)->(%0d,%0d) c=%0b",
                  edges_seen, rsp_start_x, rsp_start_y, rsp_end_x, rsp_end_y, rsp_closing,
                  want.sx, want.sy, want.ex, want.ey, want.closing));
            end
         end
      end
   end

   // Run limit far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("timeout with %0d edges still pending", pending_edges.size());
      $display("[wireframe_vertex_transform_core] ERROR");
      $finish;
   end

   initial begin
      longint unsigned x, term;
      longint          acc;
      int              k, n;
      vertex_row_type  row;

      // Build the quarter-wave table: Taylor series in Q30, rounded to Q1.14
      for (k = 0; k <= DEPTH; k++) begin
         x    = (PI_Q30 * longint'(k)) / (2 * DEPTH);
         term = x;
         acc  = longint'(x);
         for (n = 1; n <= 7; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
         end
         if (acc < 0) acc = 0;
         acc = (acc + 32768) / 65536;
         if (acc > Q14_ONE) acc = Q14_ONE;
         quarter_wave[k] = int'(acc);
      end

      // Directed rows; zero scale leaves each vertex at the position
      add_row('{mk_vertex(2047, -2048, 0, 0, 0, 0, 1), 1, 1,
                mk_edge(0, 0, 0, 0, 1), mk_edge(0, 0, 0, 0, 0)});
      add_row('{mk_vertex(-2048, 2047, 65535, 0, -8192, 8191, 1), 1, 1,
                mk_edge(-8192, 8191, -8192, 8191, 1), mk_edge(0, 0, 0, 0, 0)});
      add_row('{mk_vertex(1000, -1000, 12345, 0, 100, -200, 0), 1, 0,
                mk_edge(0, 0, 0, 0, 0), mk_edge(0, 0, 0, 0, 0)});
      add_row('{mk_vertex(-5, 7, 40000, 0, 8191, -8192, 1), 1, 2,
                mk_edge(100, -200, 8191, -8192, 0),
                mk_edge(8191, -8192, 100, -200, 1)});
      // Full-scale vertices through each quadrant start, then saturating corners
      add_row('{mk_vertex(2047, 2047, 0, 511, 0, 0, 0), 0, 0,
                mk_edge(0, 0, 0, 0, 0), mk_edge(0, 0, 0, 0, 0)});
      add_row('{mk_vertex(-2048, -2048, 16384, 511, 0, 0, 0), 0, 0,
                mk_edge(0, 0, 0, 0, 0), mk_edge(0, 0, 0, 0, 0)});
      add_row('{mk_vertex(2047, -2048, 32768, 511, 8191, 8191, 0), 0, 0,
                mk_edge(0, 0, 0, 0, 0), mk_edge(0, 0, 0, 0, 0)});
      add_row('{mk_vertex(-2048, 2047, 49152, 511, -8192, -8192, 1), 0, 0,
                mk_edge(0, 0, 0, 0, 0), mk_edge(0, 0, 0, 0, 0)});
      // Unit vertex around the table seams
      add_row('{mk_vertex(256, 0, 8192, 16, 0, 0, 0), 0, 0,
                mk_edge(0, 0, 0, 0, 0), mk_edge(0, 0, 0, 0, 0)});
      add_row('{mk_vertex(256, 0, 16383, 16, 0, 0, 0), 0, 0,
                mk_edge(0, 0, 0, 0, 0), mk_edge(0, 0, 0, 0, 0)});
      add_row('{mk_vertex(256, 0, 16448, 16, 0, 0, 0), 0, 0,
                mk_edge(0, 0, 0, 0, 0), mk_edge(0, 0, 0, 0, 0)});
      add_row('{mk_vertex(0, 256, 65535, 16, 0, 0, 0), 0, 0,
                mk_edge(0, 0, 0, 0, 0), mk_edge(0, 0, 0, 0, 0)});
      add_row('{mk_vertex(0, 256, 64, 1, -1, 1, 0), 0, 0,
                mk_edge(0, 0, 0, 0, 0), mk_edge(0, 0, 0, 0, 0)});
      add_row('{mk_vertex(1, 1, 0, 1, 0, 0, 1), 0, 0,
                mk_edge(0, 0, 0, 0, 0), mk_edge(0, 0, 0, 0, 0)});
      // Products exactly half a unit either side of zero
      add_row('{mk_vertex(1, -1, 0, 128, 0, 0, 1), 0, 0,
                mk_edge(0, 0, 0, 0, 0), mk_edge(0, 0, 0, 0, 0)});
      // Offsets pushing past both ends of the coordinate range
      add_row('{mk_vertex(-2048, 2047, 0, 511, -8192, 8191, 0), 0, 0,
                mk_edge(0, 0, 0, 0, 0), mk_edge(0, 0, 0, 0, 0)});
      add_row('{mk_vertex(2047, -2048, 0, 511, 8191, -8192, 1), 0, 0,
                mk_edge(0, 0, 0, 0, 0), mk_edge(0, 0, 0, 0, 0)});

      // Hold reset, then release it at a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the directed table
      foreach (vertex_rows[r]) begin
         row = vertex_rows[r];
         send_vertex(row.v);
         if (row.typed) begin
            if (row.n_edges >= 1) queue_edge(row.e0);
            if (row.n_edges >= 2) queue_edge(row.e1);
         end
         trace_edges(row.v, !row.typed);
      end
      drain_edges();

      // Random polygons under four handshake mixes, draining between them
      run_polygons(190);
      drain_edges();
      sender_idle_pct = 49;
      run_polygons(190);
      drain_edges();
      sender_idle_pct    = 0;
      receiver_stall_pct = 49;
      run_polygons(190);
      drain_edges();
      sender_idle_pct    = 26;
      receiver_stall_pct = 26;
      run_polygons(190);
      drain_edges();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("covered %0d vertices giving %0d edges (%0d closing) under four stall mixes",
               vertices_sent, edges_seen, closing_seen);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0) begin
         $display("[wireframe_vertex_transform_core] OK");
      end else begin
         $display("[wireframe_vertex_transform_core] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
rtl/core/wvt_pkg.sv
rtl/core/wireframe_vertex_transform_core.sv
test/tb_wireframe_vertex_transform_core.sv
